// File: src/fd_pkg.sv
// Shared constants, types and codes for the decimating FIR filter.
package fd_pkg;

    // Filter size and field widths
    localparam int MAX_TAPS   = 64;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_IDX_W = 6;
    localparam int TAP_CNT_W  = 7;
    localparam int DECIM_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Derived arithmetic and counter widths
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
    localparam int TAPS_W = $clog2(MAX_TAPS + 1);
    localparam int STEP_W = $clog2(2 * MAX_TAPS);

    // Item kinds
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM     = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    // Shift controls sent to every cell of the chain
    typedef struct packed {
        logic sample_shift;
        logic coef_shift;
    } fd_shift_t;

endpackage

// File: src/fd_if.sv
// Handshake channels of the decimating FIR filter: sample/coefficient feed, result, config.
interface fd_feed_if;
    import fd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  op;
    sample_t               sample_in;
    logic [COEF_IDX_W-1:0] coef_index;
    coef_t                 coef_value;

    modport source (output valid, output op, output sample_in, output coef_index,
                    output coef_value, input ready);
    modport sink   (input valid, input op, input sample_in, input coef_index,
                    input coef_value, output ready);
endinterface

interface fd_result_if;
    import fd_pkg::*;

    logic    valid;
    logic    ready;
    sample_t filtered_value;
    logic    saturated;

    modport source (output valid, output filtered_value, output saturated, input ready);
    modport sink   (input valid, input filtered_value, input saturated, output ready);
endinterface

interface fd_cfg_if;
    import fd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/fd_cell.sv
// One tap cell: holds one delay-line sample and one coefficient, shifts both toward the head.
module fd_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  fd_pkg::fd_shift_t shift,
    input  fd_pkg::sample_t   sample_nbr,
    input  fd_pkg::coef_t     coef_nbr,
    input  logic              coef_wr,
    input  fd_pkg::coef_t     coef_wdata,
    output fd_pkg::sample_t   sample,
    output fd_pkg::coef_t     coef
);
    import fd_pkg::*;

    sample_t sample_reg;
    coef_t   coef_reg;

    // Advance the sample from the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else if (shift.sample_shift)
        begin
            sample_reg <= sample_nbr;
        end
    end

    // Load a written coefficient, else advance from the neighbor, else hold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            priority if (coef_wr)
            begin
                coef_reg <= coef_wdata;
            end
            else if (shift.coef_shift)
            begin
                coef_reg <= coef_nbr;
            end
            else
            begin
                coef_reg <= coef_reg;
            end
        end
    end

    assign sample = sample_reg;
    assign coef   = coef_reg;

endmodule

// File: src/fd_mac.sv
// Multiply-accumulate at the chain head, with Q1.15 rounding and saturation of the sum.
module fd_mac (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  logic            in_vld,
    input  fd_pkg::sample_t sample,
    input  fd_pkg::coef_t   coef,
    output fd_pkg::sample_t filtered_value,
    output logic            saturated
);
    import fd_pkg::*;

    localparam int FRAC_W = COEF_W - 1;
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (FRAC_W - 1);
    localparam logic signed [ACC_W-1:0] POS_LIM  = ACC_W'(1) << (SAMPLE_W - 1 + FRAC_W);
    localparam logic signed [ACC_W-1:0] NEG_LIM  = -POS_LIM;
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  rounded;

    // Register the head product
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(sample) * PROD_W'(coef);
    end

    // Accumulate registered products, clear at the start of a pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else if (clear)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= in_vld;
            if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // Round half up, then clip to the Q1.15 range
    assign rounded = acc_reg + HALF_LSB;

    always_comb
    begin
        priority if (rounded >= POS_LIM)
        begin
            filtered_value = OUT_MAX;
            saturated      = 1'b1;
        end
        else if (rounded < NEG_LIM)
        begin
            filtered_value = OUT_MIN;
            saturated      = 1'b1;
        end
        else
        begin
            filtered_value = rounded[FRAC_W +: SAMPLE_W];
            saturated      = 1'b0;
        end
    end

endmodule

// File: src/fir_decimator.sv
// Top level of the decimating FIR filter: config registers, decimation phase, pass sequencer.
//
// A coefficient write or a sample that does not complete a decimation phase leaves the block idle.
// A sample that completes a phase starts a pass over the 64-cell tap chain: both the sample
// row and the coefficient row rotate through the single multiplier at the chain head, so the
// block takes no new item until its run, drain and finish states are over; finish waits
// until any earlier result is taken. Configuration writes are taken at any time on their own
// channel and must be issued while the block is idle.
module fir_decimator (
    input  logic        clk,
    input  logic        rst_n,
    fd_feed_if.sink     feed,
    fd_result_if.source result,
    fd_cfg_if.sink      cfg
);
    import fd_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic [TAP_CNT_W-1:0] tap_count_reg;
    logic [DECIM_W-1:0]   decim_factor_reg;
    logic [DECIM_W-1:0]   phase_reg;
    logic [DECIM_W-1:0]   phase_next;
    logic [DECIM_W-1:0]   factor;
    logic [TAPS_W-1:0]    eff_taps;
    logic [STEP_W-1:0]    base;
    logic [STEP_W-1:0]    last_step;

    logic    sample_accept;
    logic    coef_accept;
    logic    pass_start;
    logic    in_window;
    logic    out_load;
    logic    res_valid_reg;
    sample_t res_value_reg;
    logic    res_sat_reg;

    fd_shift_t            shift;
    sample_t              cell_sample [MAX_TAPS];
    coef_t                cell_coef   [MAX_TAPS];
    logic [MAX_TAPS-1:0]  coef_wr;
    sample_t              tail_sample;
    sample_t              mac_value;
    logic                 mac_sat;

    // Handshakes
    assign feed.ready    = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;
    assign sample_accept = feed.valid && feed.ready && (feed.op == OP_SAMPLE);
    assign coef_accept   = feed.valid && feed.ready && (feed.op == OP_COEF);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg    <= TAP_CNT_W'(64);
            decim_factor_reg <= DECIM_W'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_TAP_COUNT: tap_count_reg    <= cfg.data[TAP_CNT_W-1:0];
                CFG_DECIM:     decim_factor_reg <= cfg.data[DECIM_W-1:0];
            endcase
        end
    end

    // Effective tap count and factor
    always_comb
    begin
        priority if (tap_count_reg == '0)
        begin
            eff_taps = TAPS_W'(1);
        end
        else if (int'(tap_count_reg) > MAX_TAPS)
        begin
            eff_taps = TAPS_W'(MAX_TAPS);
        end
        else
        begin
            eff_taps = TAPS_W'(tap_count_reg);
        end
    end

    assign factor    = (decim_factor_reg == '0) ? DECIM_W'(1) : decim_factor_reg;
    assign base      = STEP_W'(MAX_TAPS) - STEP_W'(eff_taps);
    assign last_step = base + STEP_W'(MAX_TAPS - 1);

    // Decimation phase: start a pass when the count reaches or passes the factor
    assign phase_next = phase_reg + DECIM_W'(1);
    assign pass_start = sample_accept && (phase_next >= factor);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (sample_accept)
        begin
            phase_reg <= pass_start ? '0 : phase_next;
        end
    end

    // Pass sequencer
    assign out_load = (state_reg == ST_FINISH) && (!res_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pass_start)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (step_reg == last_step)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Rotation controls: samples while the step is below MAX_TAPS, coefficients from base on
    assign shift.sample_shift = sample_accept
                             || ((state_reg == ST_RUN) && (int'(step_reg) < MAX_TAPS));
    assign shift.coef_shift   = (state_reg == ST_RUN) && (step_reg >= base);
    assign in_window          = (state_reg == ST_RUN) && (step_reg >= base)
                             && (int'(step_reg) < MAX_TAPS);
    assign tail_sample        = sample_accept ? feed.sample_in : cell_sample[0];

    // Tap chain, head at cell 0 (oldest sample)
    for (genvar p = 0; p < MAX_TAPS; p++)
    begin : g_cell
        assign coef_wr[p] = coef_accept && (int'(feed.coef_index) == p);

        if (p == MAX_TAPS - 1)
        begin : g_tail
            fd_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (shift),
                .sample_nbr (tail_sample),
                .coef_nbr   (cell_coef[0]),
                .coef_wr    (coef_wr[p]),
                .coef_wdata (feed.coef_value),
                .sample     (cell_sample[p]),
                .coef       (cell_coef[p])
            );
        end
        else
        begin : g_body
            fd_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift      (shift),
                .sample_nbr (cell_sample[p+1]),
                .coef_nbr   (cell_coef[p+1]),
                .coef_wr    (coef_wr[p]),
                .coef_wdata (feed.coef_value),
                .sample     (cell_sample[p]),
                .coef       (cell_coef[p])
            );
        end
    end

    // Multiply-accumulate at the head
    fd_mac u_mac (
        .clk            (clk),
        .rst_n          (rst_n),
        .clear          (pass_start),
        .in_vld         (in_window),
        .sample         (cell_sample[0]),
        .coef           (cell_coef[0]),
        .filtered_value (mac_value),
        .saturated      (mac_sat)
    );

    // Output register: hold the item until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_value_reg <= mac_value;
            res_sat_reg   <= mac_sat;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.filtered_value = res_value_reg;
    assign result.saturated      = res_sat_reg;

    // A pass begins only right after a sample item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && step_reg == '0)
            |-> $past(feed.valid && feed.ready && feed.op == OP_SAMPLE))
        else $error("pass started without a sample item");

    // A result appears only at the end of a pass
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the end of a pass");

    // The step counter never runs past the last rotation
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= last_step))
        else $error("pass step beyond last rotation");

endmodule

// File: tb/tb.sv
// Self-checking testbench for the decimating FIR filter: directed corners, then random phases.
module tb;
    import fd_pkg::*;

    // Expected filter output: value and clip flag
    typedef struct packed {
        sample_t value;
        logic    sat;
    } fir_out_t;

    // Tracks filter state from accepted items and checks the outputs in order
    class fir_output_tracker;
        sample_t              history [MAX_TAPS];
        coef_t                coef_bank [MAX_TAPS];
        logic [TAP_CNT_W-1:0] tap_reg;
        logic [DECIM_W-1:0]   decim_reg;
        logic [7:0]           phase;
        fir_out_t             expected_outputs [$];
        int                   mismatches;
        int                   outputs_checked;
        int                   samples_taken;
        int                   coef_loads;

        function new();
            tap_reg         = TAP_CNT_W'(MAX_TAPS);
            decim_reg       = DECIM_W'(1);
            phase           = '0;
            mismatches      = 0;
            outputs_checked = 0;
            samples_taken   = 0;
            coef_loads      = 0;
            foreach (history[i])
            begin
                history[i]   = '0;
                coef_bank[i] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_TAP_COUNT)
                tap_reg = val[TAP_CNT_W-1:0];
            else if (idx == CFG_DECIM)
                decim_reg = val[DECIM_W-1:0];
        endfunction

        // Weighted sum over the newest taps, rounded to Q1.15 and clipped
        function fir_out_t filter_output();
            int       taps;
            int       k;
            longint   acc;
            longint   rounded;
            fir_out_t o;
            taps = (tap_reg == 0) ? 1 : ((tap_reg > MAX_TAPS) ? MAX_TAPS : int'(tap_reg));
            acc  = 0;
            for (k = 0; k < taps; k++)
                acc += longint'(coef_bank[k]) * longint'(history[MAX_TAPS - taps + k]);
            rounded = (acc + 64'sd16384) >>> 15;
            if (rounded > 32767)
            begin
                o.value = 16'sh7fff;
                o.sat   = 1'b1;
            end
            else if (rounded < -32768)
            begin
                o.value = 16'sh8000;
                o.sat   = 1'b1;
            end
            else
            begin
                o.value = rounded[15:0];
                o.sat   = 1'b0;
            end
            return o;
        endfunction

        function void note_feed(logic op, sample_t s, logic [COEF_IDX_W-1:0] idx, coef_t c);
            int k;
            int factor;
            if (op == OP_COEF)
            begin
                coef_bank[idx] = c;
                coef_loads++;
                return;
            end
            samples_taken++;
            // Shift the newest sample in at the top
            for (k = 0; k < MAX_TAPS - 1; k++)
                history[k] = history[k + 1];
            history[MAX_TAPS - 1] = s;
            factor = (decim_reg == 0) ? 1 : int'(decim_reg);
            phase  = phase + 8'd1;
            if (int'(phase) < factor)
                return;
            phase = '0;
            expected_outputs.push_back(filter_output());
        endfunction

        function void check_result(sample_t v, logic sat);
            fir_out_t exp_out;
            if (expected_outputs.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected output: value %0d sat %0b", v, sat);
                mismatches++;
                return;
            end
            exp_out = expected_outputs.pop_front();
            if (exp_out.value !== v || exp_out.sat !== sat)
            begin
                if (mismatches < 10)
                    $display("output %0d: expected %0d sat %0b, got %0d sat %0b",
                             outputs_checked, exp_out.value, exp_out.sat, v, sat);
                mismatches++;
            end
            outputs_checked++;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic idle_on;
    int   settings_used;

    fir_output_tracker sb;

    fd_feed_if   feed_ch();
    fd_result_if res_ch();
    fd_cfg_if    cfg_ch();

    fir_decimator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Clock: period 4
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Observe every handshake at the rising edge
    always @(posedge clk)
    begin
        if (feed_ch.valid && feed_ch.ready)
            sb.note_feed(feed_ch.op, feed_ch.sample_in, feed_ch.coef_index, feed_ch.coef_value);
        if (res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.filtered_value, res_ch.saturated);
        if (cfg_ch.valid && cfg_ch.ready)
            sb.write_reg(cfg_ch.index, cfg_ch.data);
    end

    // Result side: random stall bursts while idling is enabled
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                res_ch.ready = 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(negedge clk);
            end
            else
                res_ch.ready = 1'b1;
        end
    end

    // Present one item and hold it until taken
    task automatic send_item(input logic op, input sample_t s,
                             input logic [COEF_IDX_W-1:0] idx, input coef_t c);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            feed_ch.valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        feed_ch.valid      = 1'b1;
        feed_ch.op         = op;
        feed_ch.sample_in  = s;
        feed_ch.coef_index = idx;
        feed_ch.coef_value = c;
        @(posedge clk);
        while (!feed_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_coef(input logic [COEF_IDX_W-1:0] idx, input coef_t c);
        send_item(OP_COEF, sample_t'($urandom), idx, c);
    endtask

    task automatic push_sample(input sample_t s);
        send_item(OP_SAMPLE, s, COEF_IDX_W'($urandom), coef_t'($urandom));
    endtask

    // Random item: mostly samples, some coefficient loads, extremes now and then
    task automatic send_random_item();
        logic    op;
        sample_t s;
        coef_t   c;
        op = ($urandom_range(0, 99) < 15) ? OP_COEF : OP_SAMPLE;
        s  = sample_t'($urandom);
        c  = coef_t'($urandom);
        if ($urandom_range(0, 9) == 0)
            s = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
        if ($urandom_range(0, 9) == 0)
            c = ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
        send_item(op, s, COEF_IDX_W'($urandom), c);
    endtask

    // Drop valid, wait for every expected output, then let a full pass finish
    task automatic drain();
        feed_ch.valid = 1'b0;
        while (sb.expected_outputs.size() != 0)
            @(negedge clk);
        repeat (2 * MAX_TAPS + 12) @(negedge clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic apply_setting(input int taps, input int factor);
        logic [CFG_DATA_W-1:0] tap_word;
        tap_word    = CFG_DATA_W'(taps);
        tap_word[7] = 1'($urandom_range(0, 1));
        program_reg(CFG_TAP_COUNT, tap_word);
        program_reg(CFG_DECIM, CFG_DATA_W'(factor));
        settings_used++;
    endtask

    // Register settings for the random phases
    int phase_taps  [8] = '{64, 1, 127, 0, 17, 33, 64, 5};
    int phase_decim [8] = '{1, 2, 255, 0, 4, 7, 1, 3};

    // Main sequence
    initial
    begin
        sb                 = new();
        rst_n              = 1'b0;
        idle_on            = 1'b0;
        settings_used      = 1;
        feed_ch.valid      = 1'b0;
        feed_ch.op         = OP_SAMPLE;
        feed_ch.sample_in  = '0;
        feed_ch.coef_index = '0;
        feed_ch.coef_value = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_TAP_COUNT;
        cfg_ch.data        = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: all 64 taps, an output per sample
        load_coef(COEF_IDX_W'(0), 16'sh8000);
        load_coef(COEF_IDX_W'(63), 16'sh7fff);
        load_coef(COEF_IDX_W'(1), 16'sd12345);
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        push_sample(16'sh0000);
        push_sample(16'sh0001);
        push_sample(16'shffff);
        push_sample(16'sh5555);

        // Zero tap count and zero factor act as one; clip high on full-scale product
        drain();
        apply_setting(0, 0);
        push_sample(16'sh8000);
        push_sample(16'sh7fff);

        // Tap count above range, long phase, then lower the factor mid-phase
        drain();
        apply_setting(127, 200);
        repeat (5) push_sample(sample_t'($urandom));
        drain();
        program_reg(CFG_DECIM, CFG_DATA_W'(2));
        push_sample(16'sh0000);

        // Two full-scale negative products clip low
        drain();
        apply_setting(2, 1);
        load_coef(COEF_IDX_W'(1), 16'sh8000);
        push_sample(16'sh7fff);
        push_sample(16'sh7fff);

        // Random phases, each under its own register setting
        for (int p = 0; p < 12; p++)
        begin
            drain();
            if (p < 8)
                apply_setting(phase_taps[p], phase_decim[p]);
            else
                apply_setting($urandom_range(0, 127), $urandom_range(1, 6));
            idle_on = !(p == 5 || p == 11);
            repeat (110) send_random_item();
        end

        drain();
        $display("checked %0d outputs from %0d samples and %0d coefficient loads",
                 sb.outputs_checked, sb.samples_taken, sb.coef_loads);
        $display("over %0d tap/decimation settings, %0d mismatches",
                 settings_used, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_outputs.size() == 0)
            $display("fir_decimator: match");
        else
            $display("fir_decimator: mismatch");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #8000000;
        $display("fir_decimator: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
src/fd_pkg.sv
src/fd_if.sv
src/fd_cell.sv
src/fd_mac.sv
src/fir_decimator.sv
tb/tb.sv
